// ===== rtl/pcm_to_dac_clip_agc_defines.svh =====
// ---------------------------------------------------------------------------
// pcm_to_dac_clip_agc assertion macros
// Shared assertion wrappers; define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef PCM_TO_DAC_CLIP_AGC_DEFINES_SVH
`define PCM_TO_DAC_CLIP_AGC_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside of reset.
`define PCMDAC_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pcm_to_dac_clip_agc assertion failed");
// Checked on every clock edge, reset included.
`define PCMDAC_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("pcm_to_dac_clip_agc assertion failed");
`else
`define PCMDAC_ASSERT(name, prop)
`define PCMDAC_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== rtl/pcmdac_pkg.sv =====
// ---------------------------------------------------------------------------
// pcmdac_pkg
// Types and constants shared by the PCM to DAC converter with clip AGC.
// ---------------------------------------------------------------------------
package pcmdac_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int GAIN_W           = 17;
   localparam int SAMPLE_FRAC_BITS = 16;
   localparam int GAIN_FRAC_BITS   = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 32;

   localparam logic [GAIN_W-1:0] NOMINAL_RESET = 17'd117965;
   localparam logic [GAIN_W-1:0] ATTACK_RESET  = 17'd6554;
   localparam logic [GAIN_W-1:0] FLOOR_RESET   = 17'd6554;
   localparam logic [GAIN_W-1:0] RELEASE_RESET = 17'd131;

   typedef enum logic [1:0] {
      REG_NOMINAL_GAIN = 2'd0,
      REG_ATTACK_STEP  = 2'd1,
      REG_GAIN_FLOOR   = 2'd2,
      REG_RELEASE_STEP = 2'd3
   } pcmdac_reg_type;

   typedef enum logic [1:0] {
      FMT_STEREO     = 2'd0,
      FMT_STEREO_LSF = 2'd1,
      FMT_MONO       = 2'd2,
      FMT_MONO_LSF   = 2'd3
   } pcmdac_fmt_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SCALE,
      BK_EVAL,
      BK_REL
   } pcmdac_bk_state_type;

   typedef struct packed {
      logic [GAIN_W-1:0] nominal_gain;
      logic [GAIN_W-1:0] attack_step;
      logic [GAIN_W-1:0] gain_floor;
      logic [GAIN_W-1:0] rel_step;
   } pcmdac_cfg_type;

   // One unit of work for the back end. A stereo LSF pair carries the left
   // sample in sample_a and the right one in sample_b. A silent job produces
   // no beats and only carries a frame end.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      pcmdac_fmt_type      fmt;
      logic                fend;
      logic                silent;
   } pcmdac_job_type;

endpackage

// ===== rtl/pcmdac_csr.sv =====
// ---------------------------------------------------------------------------
// pcmdac_csr
// APB-style register file holding the gain control settings.
// ---------------------------------------------------------------------------
module pcmdac_csr import pcmdac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output pcmdac_cfg_type        cfg
);

   pcmdac_cfg_type cfg_ff;
   pcmdac_cfg_type cfg_in;
   pcmdac_reg_type reg_sel;
   logic           wr_en;
   logic [GAIN_W-1:0] rd_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = pcmdac_reg_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      rd_val = '0;
      unique case (reg_sel)
         REG_NOMINAL_GAIN: begin
            rd_val = cfg_ff.nominal_gain;
            if (wr_en) cfg_in.nominal_gain = csr_pwdata[GAIN_W-1:0];
         end
         REG_ATTACK_STEP: begin
            rd_val = cfg_ff.attack_step;
            if (wr_en) cfg_in.attack_step = csr_pwdata[GAIN_W-1:0];
         end
         REG_GAIN_FLOOR: begin
            rd_val = cfg_ff.gain_floor;
            if (wr_en) cfg_in.gain_floor = csr_pwdata[GAIN_W-1:0];
         end
         REG_RELEASE_STEP: begin
            rd_val = cfg_ff.rel_step;
            if (wr_en) cfg_in.rel_step = csr_pwdata[GAIN_W-1:0];
         end
         default: rd_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_gain <= NOMINAL_RESET;
         cfg_ff.attack_step  <= ATTACK_RESET;
         cfg_ff.gain_floor   <= FLOOR_RESET;
         cfg_ff.rel_step     <= RELEASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = CSR_DATA_W'(rd_val);
   assign cfg        = cfg_ff;

endmodule

// ===== rtl/pcmdac_front.sv =====
// ---------------------------------------------------------------------------
// pcmdac_front
// Accepts input beats, pairs LSF stereo samples and builds back-end jobs.
// ---------------------------------------------------------------------------
`include "pcm_to_dac_clip_agc_defines.svh"

module pcmdac_front import pcmdac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_pcm_sample,
   input  logic [1:0]          req_frame_format,
   input  logic                req_frame_end,
   input  logic                queue_full,
   output logic                push,
   output pcmdac_job_type      job
);

   logic                held_ff;
   logic                held_in;
   logic [SAMPLE_W-1:0] held_sample_ff;
   logic [SAMPLE_W-1:0] held_sample_in;
   logic                accept;
   pcmdac_fmt_type      fmt;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~req_stall;
   assign fmt       = pcmdac_fmt_type'(req_frame_format);

   always_comb begin
      held_in         = held_ff;
      held_sample_in  = held_sample_ff;
      push            = 1'b0;
      job.sample_a    = req_pcm_sample;
      job.sample_b    = req_pcm_sample;
      job.fmt         = fmt;
      job.fend        = req_frame_end;
      job.silent      = 1'b0;
      if (accept) begin
         if (fmt != FMT_STEREO_LSF) begin
            // Another format drops any waiting left sample.
            held_in = 1'b0;
            push    = 1'b1;
         end else if (!held_ff) begin
            if (!req_frame_end) begin
               held_in        = 1'b1;
               held_sample_in = req_pcm_sample;
            end else begin
               // A lone left sample that ends the frame only triggers release.
               push       = 1'b1;
               job.silent = 1'b1;
            end
         end else begin
            push         = 1'b1;
            job.sample_a = held_sample_ff;
            held_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      held_sample_ff <= held_sample_in;
   end

   `PCMDAC_ASSERT(a_silent_job_ends_frame, push && job.silent |-> job.fend)

endmodule

// ===== rtl/pcmdac_fifo.sv =====
// ---------------------------------------------------------------------------
// pcmdac_fifo
// Short job queue between the front end and the back end.
// ---------------------------------------------------------------------------
`include "pcm_to_dac_clip_agc_defines.svh"

module pcmdac_fifo import pcmdac_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pcmdac_job_type push_job,
   input  logic           pop,
   output pcmdac_job_type pop_job,
   output logic           full,
   output logic           empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pcmdac_job_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `PCMDAC_ASSERT(a_queue_no_overflow, push |-> !full)
   `PCMDAC_ASSERT(a_queue_no_underflow, pop |-> !empty)
   `PCMDAC_ASSERT_ALWAYS(a_queue_reset_empty, reset |=> empty)

endmodule

// ===== rtl/pcmdac_back.sv =====
// ---------------------------------------------------------------------------
// pcmdac_back
// Scales queued samples to DAC codes, runs the clip AGC and emits the beats.
// ---------------------------------------------------------------------------
`include "pcm_to_dac_clip_agc_defines.svh"

module pcmdac_back import pcmdac_pkg::*; #(
   parameter int DAC_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  pcmdac_cfg_type      cfg,
   input  pcmdac_job_type      job,
   input  logic                job_empty,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DAC_BITS-1:0] rsp_dac_code,
   output logic                rsp_was_clipped,
   output logic                rsp_run_last
);

   localparam int PROD_W   = GAIN_W + SAMPLE_W;
   localparam int SCALED_W = PROD_W + DAC_BITS - 1;
   localparam int SHIFT    = SAMPLE_FRAC_BITS + GAIN_FRAC_BITS;
   localparam int PW       = SCALED_W - SHIFT;
   localparam int CW       = ((PW > DAC_BITS) ? PW : DAC_BITS) + 2;
   localparam logic [DAC_BITS-1:0] CODE_MAX  = {DAC_BITS{1'b1}};
   localparam logic [DAC_BITS-1:0] DAC_MID   = {1'b1, {(DAC_BITS - 1){1'b0}}};
   localparam logic [DAC_BITS-1:0] DAC_SCALE = {1'b0, {(DAC_BITS - 1){1'b1}}};

   // Returns {clipped, code} for a magnitude, its sign and the midpoint offset.
   function automatic logic [DAC_BITS:0] make_code(input logic [PW-1:0] p,
                                                   input logic neg,
                                                   input logic [DAC_BITS-1:0] offset);
      logic signed [CW-1:0] off_x;
      logic signed [CW-1:0] p_x;
      logic signed [CW-1:0] c;
      logic                 under;
      logic                 over;
      logic [DAC_BITS-1:0]  code;
      off_x = $signed(CW'(offset));
      p_x   = $signed(CW'(p));
      c     = neg ? off_x - p_x : off_x + p_x;
      under = c[CW-1];
      over  = !under && (c[CW-2:0] > (CW-1)'(CODE_MAX));
      code  = under ? '0 : (over ? CODE_MAX : c[DAC_BITS-1:0]);
      return {under | over, code};
   endfunction

   pcmdac_bk_state_type state_ff;
   pcmdac_bk_state_type state_in;

   // Job registers, loaded on a pop.
   logic [SAMPLE_W-1:0] mag_a_ff;
   logic [SAMPLE_W-1:0] mag_b_ff;
   logic                neg_a_ff;
   logic                neg_b_ff;
   pcmdac_fmt_type      fmt_ff;
   logic                fend_ff;
   logic                silent_ff;

   // Datapath stages; they run freely and are consumed in the matching state.
   logic [PROD_W-1:0]   prod_a_ff;
   logic [PROD_W-1:0]   prod_b_ff;
   logic [SCALED_W-1:0] scaled_a;
   logic [SCALED_W-1:0] scaled_b;
   logic [PW-1:0]       p_a_ff;
   logic [PW-1:0]       p_b_ff;
   logic                gt_floor_ff;
   logic                gt_attack_ff;
   logic [GAIN_W-1:0]   gain_sub_ff;

   logic [GAIN_W-1:0]   gain_ff;
   logic [GAIN_W-1:0]   gain_start_ff;
   logic [GAIN_W-1:0]   gain_clip;
   logic [GAIN_W:0]     gain_sum;
   logic [GAIN_W-1:0]   gain_rel;

   logic [DAC_BITS-1:0] offset;
   logic [DAC_BITS:0]   res_a;
   logic [DAC_BITS:0]   res_b;
   logic                clip_any;
   logic [1:0]          em_last_in;

   // Output stage.
   logic                em_busy_ff;
   logic [1:0]          em_idx_ff;
   logic [1:0]          em_last_ff;
   logic                em_pair_ff;
   logic                em_clip_ff;
   logic [DAC_BITS-1:0] em_code_a_ff;
   logic [DAC_BITS-1:0] em_code_b_ff;
   logic                beat;
   logic                em_done_beat;
   logic                em_free;

   logic                advance;
   logic                ld_em;
   logic                ld_gain_clip;
   logic                ld_rel;

   assign beat         = em_busy_ff & ~rsp_stall;
   assign em_done_beat = beat & (em_idx_ff == em_last_ff);
   assign em_free      = ~em_busy_ff | em_done_beat;

   // Code evaluation and gain arithmetic.
   always_comb begin
      offset   = (fmt_ff == FMT_STEREO) ? DAC_SCALE : DAC_MID;
      res_a    = make_code(p_a_ff, neg_a_ff, offset);
      res_b    = make_code(p_b_ff, neg_b_ff, offset);
      clip_any = res_a[DAC_BITS] | ((fmt_ff == FMT_STEREO_LSF) & res_b[DAC_BITS]);
      gain_clip = gt_floor_ff ? (gt_attack_ff ? gain_sub_ff : '0) : cfg.gain_floor;
      gain_sum  = {1'b0, gain_ff} + {1'b0, cfg.rel_step};
      if (gain_ff == gain_start_ff) begin
         gain_rel = (gain_sum > {1'b0, cfg.nominal_gain}) ? cfg.nominal_gain
                                                          : gain_sum[GAIN_W-1:0];
      end else begin
         gain_rel = gain_ff;
      end
      unique case (fmt_ff)
         FMT_STEREO:     em_last_in = 2'd0;
         FMT_STEREO_LSF: em_last_in = 2'd3;
         FMT_MONO:       em_last_in = 2'd1;
         FMT_MONO_LSF:   em_last_in = 2'd3;
         default:        em_last_in = 2'd0;
      endcase
   end

   // Sequencer: next state and strobes.
   always_comb begin
      state_in     = state_ff;
      job_pop      = 1'b0;
      advance      = 1'b0;
      ld_em        = 1'b0;
      ld_gain_clip = 1'b0;
      ld_rel       = 1'b0;
      unique case (state_ff)
         BK_IDLE:  advance = 1'b1;
         BK_MUL:   state_in = BK_SCALE;
         BK_SCALE: state_in = BK_EVAL;
         BK_EVAL: begin
            if (silent_ff || em_free) begin
               ld_em        = ~silent_ff;
               ld_gain_clip = ~silent_ff & clip_any;
               if (fend_ff) begin
                  state_in = BK_REL;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         BK_REL: begin
            ld_rel  = 1'b1;
            advance = 1'b1;
         end
         default: state_in = BK_IDLE;
      endcase
      if (advance) begin
         if (!job_empty) begin
            job_pop  = 1'b1;
            state_in = BK_MUL;
         end else begin
            state_in = BK_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_STEREO;
         fend_ff   <= 1'b0;
         silent_ff <= 1'b0;
      end else if (job_pop) begin
         fmt_ff    <= job.fmt;
         fend_ff   <= job.fend;
         silent_ff <= job.silent;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         mag_a_ff <= job.sample_a[SAMPLE_W-1] ? -job.sample_a : job.sample_a;
         mag_b_ff <= job.sample_b[SAMPLE_W-1] ? -job.sample_b : job.sample_b;
         neg_a_ff <= job.sample_a[SAMPLE_W-1];
         neg_b_ff <= job.sample_b[SAMPLE_W-1];
      end
   end

   // Scaling by 2^(DAC_BITS-1)-1 is done as a shift and a subtract after the
   // multiply; the shift back truncates the magnitude, i.e. toward zero.
   assign scaled_a = (SCALED_W'(prod_a_ff) << (DAC_BITS - 1)) - SCALED_W'(prod_a_ff);
   assign scaled_b = (SCALED_W'(prod_b_ff) << (DAC_BITS - 1)) - SCALED_W'(prod_b_ff);

   always_ff @(posedge clock) begin
      prod_a_ff    <= PROD_W'(gain_ff) * PROD_W'(mag_a_ff);
      prod_b_ff    <= PROD_W'(gain_ff) * PROD_W'(mag_b_ff);
      p_a_ff       <= scaled_a[SCALED_W-1:SHIFT];
      p_b_ff       <= scaled_b[SCALED_W-1:SHIFT];
      gt_floor_ff  <= gain_ff > cfg.gain_floor;
      gt_attack_ff <= gain_ff > cfg.attack_step;
      gain_sub_ff  <= gain_ff - cfg.attack_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= NOMINAL_RESET;
         gain_start_ff <= NOMINAL_RESET;
      end else if (ld_rel) begin
         // The gain after release is also where the next frame starts.
         gain_ff       <= gain_rel;
         gain_start_ff <= gain_rel;
      end else if (ld_gain_clip) begin
         gain_ff <= gain_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_busy_ff <= 1'b0;
         em_idx_ff  <= '0;
      end else if (ld_em) begin
         em_busy_ff <= 1'b1;
         em_idx_ff  <= '0;
      end else if (beat) begin
         em_busy_ff <= ~em_done_beat;
         em_idx_ff  <= em_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_em) begin
         em_last_ff   <= em_last_in;
         em_pair_ff   <= (fmt_ff == FMT_STEREO_LSF);
         em_clip_ff   <= clip_any;
         em_code_a_ff <= res_a[DAC_BITS-1:0];
         em_code_b_ff <= res_b[DAC_BITS-1:0];
      end
   end

   // LSF pairs alternate left and right; other formats repeat one code.
   assign rsp_valid       = em_busy_ff;
   assign rsp_dac_code    = (em_pair_ff && em_idx_ff[0]) ? em_code_b_ff : em_code_a_ff;
   assign rsp_was_clipped = em_clip_ff;
   assign rsp_run_last    = (em_idx_ff == em_last_ff);

   `PCMDAC_ASSERT(a_frame_gain_set_in_release, !$stable(gain_start_ff) && !$past(reset) |-> $past(state_ff) == BK_REL)

endmodule

// ===== rtl/pcm_to_dac_clip_agc.sv =====
// ---------------------------------------------------------------------------
// pcm_to_dac_clip_agc
// PCM sample to DAC code converter with clip-driven gain control.
// ---------------------------------------------------------------------------
// Input beats carry one signed PCM sample, its frame format and a frame end
// mark. Output beats carry one DAC code, a clip flag and a mark on the last
// beat of each input's run: one beat for full stereo, two for full mono, four
// for LSF mono, and four (L, R, L, R) on the right sample of an LSF pair.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The gain settings sit behind an APB-style register port and
// must be written only while the block is idle; the block does not enforce
// this. An accepted input reaches its first output beat through the job
// queue, job registers, product and scaled registers and output register.
// The back end steps each queued sample through multiply, scale and
// evaluate, plus release at a frame end. As the gain loop runs through the
// multiplier, a sample is multiplied only after the one ahead is evaluated,
// maybe while its beats still go out. A two-entry job queue keeps the input
// side taking beats while results wait. When the receiver stalls, the current
// beat holds, the queue fills and then req_stall rises. Synchronous reset
// restores default settings and gain, drops a held left sample and all jobs.
// ---------------------------------------------------------------------------
module pcm_to_dac_clip_agc import pcmdac_pkg::*; #(
   parameter int DAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_pcm_sample,
   input  logic [1:0]            req_frame_format,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DAC_BITS-1:0]   rsp_dac_code,
   output logic                  rsp_was_clipped,
   output logic                  rsp_run_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   pcmdac_cfg_type cfg;
   pcmdac_job_type push_job;
   pcmdac_job_type pop_job;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;

   pcmdac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pcmdac_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pcm_sample   (req_pcm_sample),
      .req_frame_format (req_frame_format),
      .req_frame_end    (req_frame_end),
      .queue_full       (queue_full),
      .push             (push),
      .job              (push_job)
   );

   pcmdac_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   pcmdac_back #(
      .DAC_BITS (DAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .job             (pop_job),
      .job_empty       (queue_empty),
      .job_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dac_code    (rsp_dac_code),
      .rsp_was_clipped (rsp_was_clipped),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

// ===== dv/pcm_to_dac_clip_agc_checker.sv =====
// ---------------------------------------------------------------------------
// pcm_to_dac_clip_agc_checker
// Watches the sample, DAC and register ports of the PCM to DAC converter,
// predicts every DAC beat from the accepted samples and the gain settings,
// and compares each DAC beat with the oldest prediction.
// ---------------------------------------------------------------------------
module pcm_to_dac_clip_agc_checker import pcmdac_pkg::*; #(
   parameter int DAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_pcm_sample,
   input  logic [1:0]            req_frame_format,
   input  logic                  req_frame_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DAC_BITS-1:0]   rsp_dac_code,
   input  logic                  rsp_was_clipped,
   input  logic                  rsp_run_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    beats_owed
);

   localparam longint unsigned DAC_SCALE = (longint'(1) << (DAC_BITS - 1)) - 1;
   localparam longint          DAC_MID   = longint'(1) << (DAC_BITS - 1);
   localparam longint          CODE_MAX  = (longint'(1) << DAC_BITS) - 1;

   typedef struct packed {
      logic [DAC_BITS-1:0] code;
      logic                clipped;
      logic                last;
   } dac_beat_type;

   dac_beat_type        dac_beats_due[$];
   dac_beat_type        want;
   pcmdac_cfg_type      gain_cfg = '{NOMINAL_RESET, ATTACK_RESET, FLOOR_RESET, RELEASE_RESET};
   logic [GAIN_W-1:0]   gain_now = NOMINAL_RESET;
   logic [GAIN_W-1:0]   gain_at_start = NOMINAL_RESET;
   logic                awaiting_start = 1'b1;
   logic [SAMPLE_W-1:0] left_sample = '0;
   logic                left_pending = 1'b0;
   int                  fail_count = 0;
   int                  owed_count = 0;

   assign mismatches = fail_count;
   assign beats_owed = owed_count;

   function automatic void scale_sample(input logic [SAMPLE_W-1:0] raw, input longint offset,
                                        output logic [DAC_BITS-1:0] code,
                                        output logic clipped);
      longint          s;
      longint          c;
      longint unsigned mag;
      longint unsigned p;
      s = longint'($signed(raw));
      mag = longint'(s < 0 ? -s : s);
      p = (DAC_SCALE * longint'(gain_now) * mag) >> (SAMPLE_FRAC_BITS + GAIN_FRAC_BITS);
      c = (s < 0) ? offset - longint'(p) : offset + longint'(p);
      clipped = 1'b0;
      if (c > CODE_MAX) begin
         c = CODE_MAX;
         clipped = 1'b1;
      end
      if (c < 0) begin
         c = 0;
         clipped = 1'b1;
      end
      code = c[DAC_BITS-1:0];
   endfunction

   // A gain already at or under the floor is pinned to the floor.
   function automatic void lower_gain();
      if (gain_now > gain_cfg.gain_floor)
         gain_now = (gain_now > gain_cfg.attack_step) ? gain_now - gain_cfg.attack_step : '0;
      else
         gain_now = gain_cfg.gain_floor;
   endfunction

   function automatic void owe_beat(input logic [DAC_BITS-1:0] code, input logic clipped,
                                    input logic last);
      dac_beat_type b;
      b.code = code;
      b.clipped = clipped;
      b.last = last;
      dac_beats_due.push_back(b);
   endfunction

   task automatic predict_beats(input logic [SAMPLE_W-1:0] sample, input pcmdac_fmt_type fmt,
                                input logic fend);
      logic [DAC_BITS-1:0] code_l;
      logic [DAC_BITS-1:0] code_r;
      logic                clip_l;
      logic                clip_r;
      int                  reps;
      logic [GAIN_W:0]     raised;
      if (awaiting_start) begin
         gain_at_start = gain_now;
         awaiting_start = 1'b0;
      end
      if (fmt != FMT_STEREO_LSF)
         left_pending = 1'b0;
      case (fmt)
         FMT_STEREO: begin
            scale_sample(sample, longint'(DAC_SCALE), code_l, clip_l);
            if (clip_l)
               lower_gain();
            owe_beat(code_l, clip_l, 1'b1);
         end
         FMT_STEREO_LSF: begin
            if (!left_pending) begin
               // A left sample that closes the frame is dropped.
               if (!fend) begin
                  left_sample = sample;
                  left_pending = 1'b1;
               end
            end else begin
               scale_sample(left_sample, DAC_MID, code_l, clip_l);
               scale_sample(sample, DAC_MID, code_r, clip_r);
               clip_l = clip_l | clip_r;
               if (clip_l)
                  lower_gain();
               owe_beat(code_l, clip_l, 1'b0);
               owe_beat(code_r, clip_l, 1'b0);
               owe_beat(code_l, clip_l, 1'b0);
               owe_beat(code_r, clip_l, 1'b1);
               left_pending = 1'b0;
            end
         end
         default: begin
            reps = (fmt == FMT_MONO) ? 2 : 4;
            scale_sample(sample, DAC_MID, code_l, clip_l);
            if (clip_l)
               lower_gain();
            for (int i = 0; i < reps; i++)
               owe_beat(code_l, clip_l, i == reps - 1);
         end
      endcase
      if (fend) begin
         left_pending = 1'b0;
         if (gain_now == gain_at_start) begin
            raised = {1'b0, gain_now} + {1'b0, gain_cfg.rel_step};
            gain_now = (raised > gain_cfg.nominal_gain) ? gain_cfg.nominal_gain
                                                        : raised[GAIN_W-1:0];
         end
         awaiting_start = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_cfg = '{NOMINAL_RESET, ATTACK_RESET, FLOOR_RESET, RELEASE_RESET};
         gain_now = NOMINAL_RESET;
         gain_at_start = NOMINAL_RESET;
         awaiting_start = 1'b1;
         left_sample = '0;
         left_pending = 1'b0;
         dac_beats_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            unique case (pcmdac_reg_type'(csr_paddr[3:2]))
               REG_NOMINAL_GAIN: gain_cfg.nominal_gain = csr_pwdata[GAIN_W-1:0];
               REG_ATTACK_STEP:  gain_cfg.attack_step  = csr_pwdata[GAIN_W-1:0];
               REG_GAIN_FLOOR:   gain_cfg.gain_floor   = csr_pwdata[GAIN_W-1:0];
               REG_RELEASE_STEP: gain_cfg.rel_step     = csr_pwdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_beats(req_pcm_sample, pcmdac_fmt_type'(req_frame_format), req_frame_end);
         if (rsp_valid && !rsp_stall) begin
            if (dac_beats_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected DAC beat: code %0d clip %0b last %0b",
                           rsp_dac_code, rsp_was_clipped, rsp_run_last);
            end else begin
               want = dac_beats_due.pop_front();
               if (want.code !== rsp_dac_code || want.clipped !== rsp_was_clipped ||
                   want.last !== rsp_run_last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("DAC beat mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                              want.code, want.clipped, want.last,
                              rsp_dac_code, rsp_was_clipped, rsp_run_last);
               end
            end
         end
      end
      owed_count = dac_beats_due.size();
   end

endmodule

// ===== dv/tb_pcm_to_dac_clip_agc.sv =====
// ---------------------------------------------------------------------------
// tb_pcm_to_dac_clip_agc
// Drives PCM samples and gain settings into the PCM to DAC converter.
// A directed set covers sample extremes, every frame format and the stereo
// LSF corner cases; random frames follow under several gain settings, with
// random gaps on both channels. The checker beside the block does the
// prediction and comparison.
// ---------------------------------------------------------------------------
module tb_pcm_to_dac_clip_agc;
   import pcmdac_pkg::*;

   localparam int DAC_BITS      = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_SAMPLES = 30;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_pcm_sample = '0;
   logic [1:0]            req_frame_format = FMT_STEREO;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DAC_BITS-1:0]   rsp_dac_code;
   logic                  rsp_was_clipped;
   logic                  rsp_run_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    beats_owed;
   logic                  quiet = 1'b0;
   int                    cycle_count = 0;
   int                    samples_sent = 0;

   pcm_to_dac_clip_agc #(.DAC_BITS(DAC_BITS)) uut (.*);

   pcm_to_dac_clip_agc_checker #(.DAC_BITS(DAC_BITS)) agc_check (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < 27);

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input pcmdac_fmt_type fmt,
                              input logic fend);
      while (!quiet && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pcm_sample <= sample;
      req_frame_format <= fmt;
      req_frame_end <= fend;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   // Stereo LSF frames are sent as whole left/right pairs.
   task automatic send_frame();
      pcmdac_fmt_type fmt;
      int             pairs;
      fmt = pcmdac_fmt_type'($urandom_range(3));
      pairs = $urandom_range(1, 5);
      for (int i = 0; i < pairs; i++) begin
         if (fmt == FMT_STEREO_LSF)
            send_sample(pick_sample(), fmt, 1'b0);
         send_sample(pick_sample(), fmt, i == pairs - 1);
      end
   endtask

   task automatic run_random(input int count);
      int stop_at;
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) begin
         if ($urandom_range(99) < 80)
            send_frame();
         else
            send_sample(pick_sample(), pcmdac_fmt_type'($urandom_range(3)),
                        $urandom_range(3) == 0);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (beats_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back writes keep psel high; the caller drops it afterwards.
   task automatic write_reg(input pcmdac_reg_type idx, input logic [GAIN_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[GAIN_W-1:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] nominal, input logic [GAIN_W-1:0] attack,
                            input logic [GAIN_W-1:0] floor_gain,
                            input logic [GAIN_W-1:0] rel_step);
      drain();
      write_reg(REG_NOMINAL_GAIN, nominal);
      write_reg(REG_ATTACK_STEP, attack);
      write_reg(REG_GAIN_FLOOR, floor_gain);
      write_reg(REG_RELEASE_STEP, rel_step);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(16'h7FFF, FMT_STEREO, 1'b0);
      send_sample(16'h8000, FMT_STEREO, 1'b0);
      send_sample(16'h0000, FMT_STEREO, 1'b0);
      send_sample(16'hFFFF, FMT_STEREO, 1'b1);
      send_sample(16'h7FFF, FMT_MONO, 1'b0);
      send_sample(16'h8000, FMT_MONO, 1'b1);
      send_sample(16'h7FFF, FMT_MONO_LSF, 1'b0);
      send_sample(16'h8000, FMT_MONO_LSF, 1'b0);
      send_sample(16'h0001, FMT_MONO_LSF, 1'b1);
      send_sample(16'h8000, FMT_STEREO_LSF, 1'b0);
      send_sample(16'h7FFF, FMT_STEREO_LSF, 1'b0);
      send_sample(16'h1234, FMT_STEREO_LSF, 1'b0);
      send_sample(16'hEDCB, FMT_STEREO_LSF, 1'b1);
      // A left sample that carries the frame end produces nothing.
      send_sample(16'h4000, FMT_STEREO_LSF, 1'b1);
      // A held left sample is dropped when another format arrives.
      send_sample(16'h5555, FMT_STEREO_LSF, 1'b0);
      send_sample(16'hAAAA, FMT_STEREO, 1'b1);
      send_sample(16'h2222, FMT_STEREO_LSF, 1'b0);
      send_sample(16'hC000, FMT_MONO_LSF, 1'b0);
      send_sample(16'h3333, FMT_MONO, 1'b1);
      send_sample(16'h0000, FMT_STEREO_LSF, 1'b0);
      send_sample(16'hFFFF, FMT_STEREO_LSF, 1'b1);

      drain();
      quiet <= 1'b1;
      run_random(PHASE_SAMPLES);
      quiet <= 1'b0;

      set_gains(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      run_random(PHASE_SAMPLES);
      set_gains('0, '0, '0, '0);
      run_random(PHASE_SAMPLES);
      set_gains(GAIN_W'($urandom_range(131071)), GAIN_W'($urandom_range(131071)),
                GAIN_W'($urandom_range(131071)), GAIN_W'($urandom_range(131071)));
      run_random(PHASE_SAMPLES);
      set_gains(17'd100000, ATTACK_RESET, FLOOR_RESET, 17'd5000);
      run_random(PHASE_SAMPLES);

      drain();
      @(negedge clock);
      if (mismatches == 0 && beats_owed == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
